// File: hdl/timestamped_sample_interpolator_top_assert.svh
// Assertion macros for the timestamped sample interpolator.
`ifndef TIMESTAMPED_SAMPLE_INTERPOLATOR_TOP_ASSERT_SVH
`define TIMESTAMPED_SAMPLE_INTERPOLATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TSI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TSI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TSI_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define TSI_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hdl/tsi_pkg.sv
// Shared types and constants for the timestamped sample interpolator.
package tsi_pkg;
    localparam int Depth = 64;
    localparam int AddrW = $clog2(Depth);
    localparam int CntW = AddrW + 1;
    localparam int TimeW = 48;
    localparam int SampW = 32;

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_TRUNC = 2'd1;
    localparam logic [1:0] ACT_INTERP = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [TimeW-1:0] time_req;
        logic [1:0] device;
        logic signed [SampW-1:0] x_value;
        logic signed [SampW-1:0] y_value;
        logic signed [SampW-1:0] z_value;
        logic [AddrW-1:0] hint_index;
    } t_in_item;

    typedef struct packed {
        logic [TimeW-1:0] out_time;
        logic [1:0] out_device;
        logic signed [SampW-1:0] out_x;
        logic signed [SampW-1:0] out_y;
        logic signed [SampW-1:0] out_z;
        logic exact_hit;
        logic [1:0] status;
        logic [CntW-1:0] occupancy;
    } t_out_item;

    typedef struct packed {
        logic [TimeW-1:0] t;
        logic [1:0] dev;
        logic signed [SampW-1:0] x;
        logic signed [SampW-1:0] y;
        logic signed [SampW-1:0] z;
    } t_entry;

    typedef enum logic [3:0] {
        S_IDLE, S_HREAD, S_HCHK, S_WREAD, S_WCHK, S_TREAD, S_TCHK,
        S_DIV, S_MUL, S_SUM, S_OUT
    } t_state;
endpackage

// File: hdl/tsi_cmd_queue.sv
// Front end: two-entry command queue between the input port and the engine.
module tsi_cmd_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  tsi_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output tsi_pkg::t_in_item o_item
);
    import tsi_pkg::*;
    t_in_item r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_take && o_valid) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_take && o_valid};
        end
    end
endmodule

// File: hdl/tsi_engine.sv
// Back end: ring storage, search walk, weight divider and blend.
module tsi_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_take,
    input  tsi_pkg::t_in_item  i_item,
    output logic               o_res_valid,
    input  logic               i_res_free,
    output tsi_pkg::t_out_item o_res
);
    import tsi_pkg::*;

    t_entry mem [Depth];
    t_entry r_rd;
    logic [AddrW-1:0] r_rd_addr;
    logic r_wen;
    logic [AddrW-1:0] r_wa;
    t_entry r_wd;

    t_state r_state, n_state;
    t_in_item r_cmd;
    logic [AddrW-1:0] r_oldest;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_i;
    logic r_up;
    t_entry r_a, r_b;
    logic [TimeW:0] r_rem;
    logic [15:0] r_w;
    logic [4:0] r_bit;
    logic [1:0] r_axis;
    logic signed [SampW+16:0] r_prod [3];
    t_out_item r_res;
    logic r_res_valid;

    // Read port: address picked by state, registered data.
    always_ff @(posedge i_clk) begin
        if (r_wen) mem[r_wa] <= r_wd;
        r_rd <= mem[r_rd_addr];
    end

    logic [TimeW-1:0] tq;
    assign tq = r_cmd.time_req;
    logic [TimeW-1:0] den;
    assign den = r_b.t - r_a.t;
    logic [TimeW:0] rem2;
    assign rem2 = {r_rem[TimeW-1:0], 1'b0};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && !r_res_valid) begin
                case (i_item.action)
                    ACT_PUSH: n_state = S_OUT;
                    ACT_TRUNC: n_state = (r_count > 7'd2) ? S_TREAD : S_OUT;
                    ACT_INTERP: n_state = ({1'b0, i_item.hint_index} < r_count) ?
                                          S_HREAD : S_OUT;
                    default: n_state = S_OUT;
                endcase
            end
            S_HREAD: n_state = S_HCHK;
            S_HCHK: n_state = (r_rd.t == tq) ? S_OUT : S_WREAD;
            S_WREAD: n_state = S_WCHK;
            S_WCHK: n_state = S_WREAD;
            S_TREAD: n_state = S_TCHK;
            S_TCHK: n_state = (r_rd.t < tq && r_count > 7'd3) ? S_TREAD : S_OUT;
            S_DIV: n_state = (r_bit == 5'd15) ? S_MUL : S_DIV;
            S_MUL: n_state = (r_axis == 2'd2) ? S_SUM : S_MUL;
            S_SUM: n_state = S_OUT;
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_take = (r_state == S_IDLE) && i_valid && !r_res_valid;

    // Walk bookkeeping: r_a holds the candidate entry, r_b its successor.
    // r_i is the index of r_a; a WREAD/WCHK pair fetches one entry.
    logic r_phase;
    always_comb begin
        r_rd_addr = r_oldest;
        case (r_state)
            S_HREAD: r_rd_addr = r_oldest + r_cmd.hint_index;
            S_WREAD: r_rd_addr = r_oldest + r_i[AddrW-1:0] + AddrW'(r_phase);
            S_TREAD: r_rd_addr = r_oldest + AddrW'(1);
            default: r_rd_addr = r_oldest;
        endcase
    end

    logic signed [SampW-1:0] ax, bx;
    logic signed [SampW:0] dd;
    always_comb begin
        case (r_axis)
            2'd0: begin ax = r_a.x; bx = r_b.x; end
            2'd1: begin ax = r_a.y; bx = r_b.y; end
            default: begin ax = r_a.z; bx = r_b.z; end
        endcase
        dd = {bx[SampW-1], bx} - {ax[SampW-1], ax};
    end

    // Status of a command that is settled when it is taken.
    t_out_item idle_res;
    always_comb begin
        idle_res = '0;
        if (i_item.action == ACT_PUSH && r_count == CntW'(Depth))
            idle_res.status = ST_FULL;
        if (i_item.action == ACT_INTERP && !({1'b0, i_item.hint_index} < r_count))
            idle_res.status = ST_MISS;
    end

    always_ff @(posedge i_clk) begin
        r_wen <= o_take && i_item.action == ACT_PUSH && r_count != CntW'(Depth);
        case (r_state)
            S_IDLE: if (o_take) begin
                r_cmd <= i_item;
                r_res <= idle_res;
                if (i_item.action == ACT_PUSH && r_count != CntW'(Depth)) begin
                    r_wa <= r_oldest + r_count[AddrW-1:0];
                    r_wd <= '{t: i_item.time_req, dev: i_item.device, x: i_item.x_value,
                              y: i_item.y_value, z: i_item.z_value};
                end
                r_i <= {1'b0, i_item.hint_index};
                r_phase <= 1'b0;
            end
            S_HCHK: begin
                r_up <= r_rd.t < tq;
                if (r_rd.t == tq) begin
                    r_res.out_time <= r_rd.t;
                    r_res.out_device <= r_rd.dev;
                    r_res.out_x <= r_rd.x;
                    r_res.out_y <= r_rd.y;
                    r_res.out_z <= r_rd.z;
                    r_res.exact_hit <= 1'b1;
                end
            end
            S_WCHK: begin
                if (!r_phase) begin
                    r_a <= r_rd;
                    if (r_rd.t > tq) begin
                        // Move; stepping backward or forward by direction.
                        if (r_up) begin
                            r_i <= r_i + 1'b1;
                            if (r_i + 1'b1 >= r_count) r_res.status <= ST_MISS;
                        end else begin
                            r_i <= r_i - 1'b1;
                            if (r_i == '0) r_res.status <= ST_MISS;
                        end
                    end else if (r_i + 1'b1 >= r_count) begin
                        r_res.status <= ST_MISS;
                    end else begin
                        r_phase <= 1'b1;
                    end
                end else begin
                    r_phase <= 1'b0;
                    if (tq >= r_rd.t) begin
                        if (r_up) begin
                            r_i <= r_i + 1'b1;
                            if (r_i + 1'b1 >= r_count) r_res.status <= ST_MISS;
                        end else begin
                            r_i <= r_i - 1'b1;
                            if (r_i == '0) r_res.status <= ST_MISS;
                        end
                    end else begin
                        r_b <= r_rd;
                        r_rem <= {1'b0, tq - r_a.t};
                        r_bit <= '0;
                        r_w <= '0;
                        r_axis <= '0;
                    end
                end
            end
            S_TCHK: ;
            S_DIV: begin
                r_bit <= r_bit + 1'b1;
                if (rem2 >= {1'b0, den}) begin
                    r_rem <= rem2 - {1'b0, den};
                    r_w <= {r_w[14:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_w <= {r_w[14:0], 1'b0};
                end
            end
            S_MUL: begin
                r_prod[r_axis] <= $signed({1'b0, r_w}) * dd;
                r_axis <= r_axis + 1'b1;
            end
            S_SUM: begin
                r_res.out_time <= tq;
                r_res.out_device <= r_b.dev;
                r_res.out_x <= r_a.x + SampW'(r_prod[0] >>> 16);
                r_res.out_y <= r_a.y + SampW'(r_prod[1] >>> 16);
                r_res.out_z <= r_a.z + SampW'(r_prod[2] >>> 16);
            end
            default: ;
        endcase
    end

    // The walk state machine: WCHK chooses between the next fetch, the
    // divider and the result.
    logic wchk_done_miss, wchk_bracket;
    always_comb begin
        wchk_done_miss = 1'b0;
        wchk_bracket = 1'b0;
        if (!r_phase) begin
            if (r_rd.t > tq) begin
                wchk_done_miss = r_up ? (r_i + 1'b1 >= r_count) : (r_i == '0);
            end else if (r_i + 1'b1 >= r_count) begin
                wchk_done_miss = 1'b1;
            end
        end else if (tq >= r_rd.t) begin
            wchk_done_miss = r_up ? (r_i + 1'b1 >= r_count) : (r_i == '0);
        end else begin
            wchk_bracket = 1'b1;
        end
    end

    t_state s_next;
    always_comb begin
        s_next = n_state;
        if (r_state == S_WCHK) begin
            if (wchk_done_miss) s_next = S_OUT;
            else if (wchk_bracket) s_next = S_DIV;
            else s_next = S_WREAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oldest <= '0;
            r_count <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state <= s_next;
            if (r_state == S_IDLE && o_take && i_item.action == ACT_PUSH &&
                r_count != CntW'(Depth))
                r_count <= r_count + 1'b1;
            if (r_state == S_TCHK && r_rd.t < tq) begin
                r_oldest <= r_oldest + 1'b1;
                r_count <= r_count - 1'b1;
            end
            if (r_state == S_OUT) r_res_valid <= 1'b1;
            else if (i_res_free) r_res_valid <= 1'b0;
        end
    end

    assign o_res_valid = r_res_valid;
    always_comb begin
        o_res = r_res;
        o_res.occupancy = r_count;
        if (r_res.status == ST_MISS) begin
            o_res = '0;
            o_res.status = ST_MISS;
            o_res.occupancy = r_count;
        end
    end
endmodule

// File: hdl/tsi_out_queue.sv
// Result register stage toward the output port.
module tsi_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_free,
    input  tsi_pkg::t_out_item i_item,
    output logic               o_empty,
    input  logic               i_pop,
    output tsi_pkg::t_out_item o_item
);
    import tsi_pkg::*;
    t_out_item r_item;
    logic r_full;
    logic r_seen;

    assign o_empty = !r_full;
    assign o_item = r_item;
    assign o_free = !r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_seen <= 1'b0;
        end else begin
            if (i_valid && !r_seen) begin
                r_full <= 1'b1;
                r_seen <= 1'b1;
            end else if (r_full && i_pop) begin
                r_full <= 1'b0;
            end else if (!r_full && r_seen) begin
                r_seen <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !r_seen) r_item <= i_item;
    end
endmodule

// File: hdl/timestamped_sample_interpolator_top.sv
// Top level of the timestamped sample interpolator.
// Input channel: push with full; one beat is a push, truncate or
// interpolate command. A two-entry command queue takes beats while the
// engine works. Result channel: empty with pop; every command yields
// exactly one result beat, in command order.
// A push, a dropped push, an unused code or a query whose hint lies
// outside the ring goes straight to the result; an exact hit at the hint
// ends after the hint read. A truncate checks one entry at a time. An
// interpolate reads the hint entry, walks forward or backward entry by
// entry, then runs the bit-serial weight divider, the three multiplies
// and the sum.
// Commands run one at a time; each holds the engine until its result
// has been handed off to the result register stage.
// Synchronous active-low reset empties the ring and both queues; the
// sample memory itself is not cleared.
// When the receiver stalls, the held result blocks the engine and the
// command queue fills, then full rises.
module timestamped_sample_interpolator_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  tsi_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output tsi_pkg::t_out_item o_item
);
    import tsi_pkg::*;
    `include "timestamped_sample_interpolator_top_assert.svh"

    logic q_valid, q_take, e_valid, e_free;
    t_in_item q_item;
    t_out_item e_res;

    tsi_cmd_queue u_q (.i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item,
                       .o_valid(q_valid), .i_take(q_take), .o_item(q_item));
    tsi_engine u_e (.i_clk, .i_rst_n, .i_valid(q_valid), .o_take(q_take),
                    .i_item(q_item), .o_res_valid(e_valid), .i_res_free(e_free),
                    .o_res(e_res));
    tsi_out_queue u_o (.i_clk, .i_rst_n, .i_valid(e_valid), .o_free(e_free),
                       .i_item(e_res), .o_empty(empty), .i_pop(pop), .o_item);

    `TSI_ASSERT_IMPL(a_occ, i_clk, i_rst_n, !empty, o_item.occupancy <= 7'd64)
    `TSI_ASSERT_IMPL(a_hit, i_clk, i_rst_n, !empty && o_item.exact_hit,
                     o_item.status == ST_OK)
    `TSI_ASSERT_NEXT(a_take, i_clk, i_rst_n, q_take, !q_take)
endmodule
